### design/gaups_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the gimbal attitude unwrap and PI stabilizer.
// Holds request kinds, register indexes and the CORDIC arctangent table.
package gaups_pkg;

  typedef enum logic [1:0] {
    FUNC_IMU    = 2'd0,
    FUNC_TICK   = 2'd1,
    FUNC_TARGET = 2'd2,
    FUNC_STAB   = 2'd3
  } func_e;

  localparam logic [1:0] REG_YAW_KP   = 2'd0;
  localparam logic [1:0] REG_PITCH_KP = 2'd1;
  localparam logic [1:0] REG_GAIN_I   = 2'd2;
  localparam logic [1:0] REG_INT_LIM  = 2'd3;

  localparam int unsigned AtanLen = 24;
  localparam int unsigned CfgW    = 31;
  localparam int unsigned InDataW = 104;
  localparam int unsigned OutDataW = 48;

  function automatic logic [31:0] atan_turns(input logic [4:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

### design/gimbal_attitude_unwrap_pi_stabilizer_core.sv
`timescale 1ns / 1ps
// IMU request: the quaternion products on the shared multiplier, then two CORDIC runs
// of min(CORDIC_STEPS,24) iterations each on the shared CORDIC datapath, then one
// update. Tick: per axis, the divide by 1000 is done as two reciprocal multiplies on
// the shared multiplier with a final correction, plus output wait. Target: the result
// is registered straight from the request.
// One request at a time; s_axis_tready is high only when idle. Reset is asynchronous,
// active low, restores register defaults and clears the control state and accumulators.
module gimbal_attitude_unwrap_pi_stabilizer_core #(
  parameter int unsigned CORDIC_STEPS   = 16,
  parameter int unsigned TICK_PERIOD_MS = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // quat_w, quat_x, quat_y, quat_z, axis_select, target_angle, enable, zero pad
  input  logic [gaups_pkg::InDataW-1:0]    s_axis_tdata,
  // func
  input  logic [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // position_cmd, velocity_ff
  output logic [gaups_pkg::OutDataW-1:0]   m_axis_tdata,
  // motor_axis
  output logic                             m_axis_tuser,
  output logic                             m_axis_tlast,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_addr_i,
  input  logic [gaups_pkg::CfgW-1:0]       cfg_wdata_i
);
  import gaups_pkg::*;

  localparam int unsigned NSteps = (CORDIC_STEPS > AtanLen) ? AtanLen : CORDIC_STEPS;
  localparam logic [4:0] LastStep = 5'(NSteps - 1);
  localparam logic [16:0] TickK = 17'(TICK_PERIOD_MS);
  localparam int unsigned CW = 37;
  localparam int unsigned PW = 51;
  localparam int unsigned DW = 40;
  localparam logic [23:0] Thousand = 24'd1000;
  localparam logic [16:0] Recip1000 = 17'd16777;

  typedef enum logic [4:0] {
    S_IDLE, S_MUL, S_CSET, S_CIT, S_CEND, S_UPD, S_TERR, S_TM1, S_TDL,
    S_TQ1, S_TR1, S_TQ2, S_TR2, S_TACC, S_TM2, S_TM3, S_TM4, S_TFF, S_OUT
  } state_e;

  state_e state_q;
  logic [15:0] yaw_kp_q, pitch_kp_q, gain_i_q;
  logic [30:0] int_lim_q;
  logic [15:0] qw_q, qx_q, qy_q, qz_q;
  logic [2:0]  mcnt_q;
  logic signed [32:0] pn_q, pd_q, yn_q, yd_q;
  logic signed [PW-1:0] prod_q, v_q;
  logic signed [CW-1:0] cx_q, cy_q;
  logic [31:0] ang_q;
  logic [4:0]  it_q;
  logic        ax_q;
  logic [15:0] rp_q, ry_q, prev_p_q, prev_y_q;
  logic [31:0] ptot_q, ytot_q, pgoal_q, ygoal_q, pacc_q, yacc_q;
  logic        first_q, stab_q;
  logic signed [32:0] err_q;
  logic [DW-1:0] dvd_q;
  logic [31:0] quo_q;
  logic        neg_q;
  logic        ovalid_q, oaxis_q, olast_q;
  logic [31:0] opos_q;
  logic [15:0] off_q;

  logic signed [33:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [PW-1:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MUL: begin
        unique case (mcnt_q)
          3'd0: begin mul_a = 34'($signed(qw_q)); mul_b = 17'($signed(qx_q)); end
          3'd1: begin mul_a = 34'($signed(qy_q)); mul_b = 17'($signed(qz_q)); end
          3'd2: begin mul_a = 34'($signed(qx_q)); mul_b = 17'($signed(qx_q)); end
          3'd3: begin mul_a = 34'($signed(qy_q)); mul_b = 17'($signed(qy_q)); end
          3'd4: begin mul_a = 34'($signed(qw_q)); mul_b = 17'($signed(qz_q)); end
          3'd5: begin mul_a = 34'($signed(qx_q)); mul_b = 17'($signed(qy_q)); end
          default: begin mul_a = 34'($signed(qz_q)); mul_b = 17'($signed(qz_q)); end
        endcase
      end
      S_TM1: begin mul_a = 34'(err_q); mul_b = $signed(TickK); end
      S_TQ1: begin
        mul_a = $signed({2'b0, dvd_q[DW-1:8]});
        mul_b = $signed(Recip1000);
      end
      S_TQ2: begin
        mul_a = $signed({10'b0, dvd_q[23:0]});
        mul_b = $signed(Recip1000);
      end
      S_TM2: begin
        mul_a = 34'(err_q);
        mul_b = $signed({1'b0, ax_q ? pitch_kp_q : yaw_kp_q});
      end
      S_TM3: begin
        mul_a = 34'($signed(ax_q ? pacc_q : yacc_q));
        mul_b = $signed({1'b0, gain_i_q});
      end
      default: ;
    endcase
  end

  assign mul_p = PW'(mul_a * mul_b);

  logic signed [32:0] csel_num, csel_den;
  logic signed [CW-1:0] cyv, cxv, cxs, cys;
  logic [31:0] ang_rnd;
  logic [15:0] dp, dy;
  logic [31:0] quo1;
  logic [DW-1:0] quo1_x1000;
  logic [15:0] quo2;
  logic [23:0] quo2_x1000, rem_lo;
  logic signed [40:0] qv;
  logic signed [41:0] nsum, nlim;
  logic signed [61:0] v62, v1000, vrnd;
  logic signed [37:0] ffq;
  logic signed [38:0] ffs;
  logic [15:0] ffsat;

  always_comb begin
    csel_num = ax_q ? pn_q : yn_q;
    csel_den = ax_q ? pd_q : yd_q;
    cyv = CW'(csel_num) <<< 1;
    cxv = (CW'(1) <<< 28) - (CW'(csel_den) <<< 1);
    cxs = cx_q >>> it_q;
    cys = cy_q >>> it_q;
    ang_rnd = ang_q + 32'h8000;
    dp = rp_q - prev_p_q;
    dy = ry_q - prev_y_q;
    quo1 = prod_q[47:16];
    quo1_x1000 = ({8'd0, quo1} << 10) - ({8'd0, quo1} << 4) - ({8'd0, quo1} << 3);
    quo2 = prod_q[39:24];
    quo2_x1000 = ({8'd0, quo2} << 10) - ({8'd0, quo2} << 4) - ({8'd0, quo2} << 3);
    rem_lo = dvd_q[23:0] - quo2_x1000;
    qv = neg_q ? -$signed({9'd0, quo_q}) : $signed({9'd0, quo_q});
    nsum = 42'($signed(ax_q ? pacc_q : yacc_q)) + 42'(qv);
    nlim = $signed({11'd0, int_lim_q});
    v62 = 62'(v_q);
    v1000 = (v62 <<< 10) - (v62 <<< 4) - (v62 <<< 3);
    vrnd = v1000 + (v1000[61] ? 62'sh0FFFFFF : 62'sh0);
    ffq = vrnd[61:24];
    ffs = ax_q ? 39'(ffq) : -39'(ffq);
    if (ffs > 39'sd32767) ffsat = 16'h7FFF;
    else if (ffs < -39'sd32768) ffsat = 16'h8000;
    else ffsat = ffs[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_kp_q   <= 16'd3840;
      pitch_kp_q <= 16'd3840;
      gain_i_q   <= 16'd6400;
      int_lim_q  <= 31'd327680;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_YAW_KP:   yaw_kp_q   <= cfg_wdata_i[15:0];
        REG_PITCH_KP: pitch_kp_q <= cfg_wdata_i[15:0];
        REG_GAIN_I:   gain_i_q   <= cfg_wdata_i[15:0];
        default:      int_lim_q  <= cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      prev_p_q <= '0;
      prev_y_q <= '0;
      ptot_q   <= '0;
      ytot_q   <= '0;
      pgoal_q  <= '0;
      ygoal_q  <= '0;
      pacc_q   <= '0;
      yacc_q   <= '0;
      first_q  <= 1'b1;
      stab_q   <= 1'b0;
      ovalid_q <= 1'b0;
      ax_q     <= 1'b0;
      mcnt_q   <= '0;
      it_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            unique case (func_e'(s_axis_tuser))
              FUNC_IMU: begin
                qw_q <= s_axis_tdata[15:0];
                qx_q <= s_axis_tdata[31:16];
                qy_q <= s_axis_tdata[47:32];
                qz_q <= s_axis_tdata[63:48];
                pn_q <= '0; pd_q <= '0; yn_q <= '0; yd_q <= '0;
                mcnt_q <= '0;
                ax_q <= 1'b1;
                state_q <= S_MUL;
              end
              FUNC_TICK: begin
                if (stab_q) begin
                  ax_q <= 1'b1;
                  state_q <= S_TERR;
                end
              end
              FUNC_TARGET: begin
                if (s_axis_tdata[64]) pgoal_q <= s_axis_tdata[96:65];
                else ygoal_q <= s_axis_tdata[96:65];
                oaxis_q  <= s_axis_tdata[64];
                opos_q   <= s_axis_tdata[96:65];
                off_q    <= '0;
                olast_q  <= 1'b1;
                ovalid_q <= 1'b1;
                ax_q     <= 1'b0;
                state_q  <= S_OUT;
              end
              default: stab_q <= s_axis_tdata[97];
            endcase
          end
        end
        S_MUL: begin
          prod_q <= mul_p;
          unique case (mcnt_q)
            3'd1, 3'd2: pn_q <= pn_q + prod_q[32:0];
            3'd3: pd_q <= pd_q + prod_q[32:0];
            3'd4: begin pd_q <= pd_q + prod_q[32:0]; yd_q <= yd_q + prod_q[32:0]; end
            3'd5, 3'd6: yn_q <= yn_q + prod_q[32:0];
            3'd7: yd_q <= yd_q + prod_q[32:0];
            default: ;
          endcase
          mcnt_q <= mcnt_q + 3'd1;
          if (mcnt_q == 3'd7) state_q <= S_CSET;
        end
        S_CSET: begin
          it_q <= '0;
          if (cxv == '0 && cyv == '0) begin
            ang_q <= '0;
            state_q <= S_CEND;
          end else begin
            if (cxv < 0) begin
              cx_q <= -cxv; cy_q <= -cyv; ang_q <= 32'h80000000;
            end else begin
              cx_q <= cxv; cy_q <= cyv; ang_q <= '0;
            end
            state_q <= S_CIT;
          end
        end
        S_CIT: begin
          if (cy_q > 0) begin
            cx_q <= cx_q + cys; cy_q <= cy_q - cxs; ang_q <= ang_q + atan_turns(it_q);
          end else begin
            cx_q <= cx_q - cys; cy_q <= cy_q + cxs; ang_q <= ang_q - atan_turns(it_q);
          end
          it_q <= it_q + 5'd1;
          if (it_q == LastStep) state_q <= S_CEND;
        end
        S_CEND: begin
          if (ax_q) begin
            rp_q <= ang_rnd[31:16];
            ax_q <= 1'b0;
            state_q <= S_CSET;
          end else begin
            ry_q <= ang_rnd[31:16];
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          if (first_q) begin
            ptot_q <= '0; ytot_q <= '0; pgoal_q <= '0; ygoal_q <= '0;
            first_q <= 1'b0;
          end else begin
            ptot_q <= ptot_q + {{16{dp[15]}}, dp};
            ytot_q <= ytot_q + {{16{dy[15]}}, dy};
          end
          prev_p_q <= rp_q;
          prev_y_q <= ry_q;
          state_q <= S_IDLE;
        end
        S_TERR: begin
          err_q <= ax_q ? (33'($signed(pgoal_q)) - 33'($signed(ptot_q)))
                        : (33'($signed(ygoal_q)) - 33'($signed(ytot_q)));
          state_q <= S_TM1;
        end
        S_TM1: begin
          prod_q <= mul_p;
          state_q <= S_TDL;
        end
        S_TDL: begin
          neg_q <= prod_q[PW-1];
          dvd_q <= prod_q[PW-1] ? DW'(-prod_q) : DW'(prod_q);
          state_q <= S_TQ1;
        end
        S_TQ1: begin
          prod_q <= mul_p;
          state_q <= S_TR1;
        end
        S_TR1: begin
          quo_q <= quo1;
          dvd_q <= dvd_q - quo1_x1000;
          state_q <= S_TQ2;
        end
        S_TQ2: begin
          prod_q <= mul_p;
          state_q <= S_TR2;
        end
        S_TR2: begin
          quo_q <= quo_q + {16'd0, quo2} + {31'd0, (rem_lo >= Thousand)};
          state_q <= S_TACC;
        end
        S_TACC: begin
          if (ax_q) begin
            if (nsum > nlim) pacc_q <= {1'b0, int_lim_q};
            else if (nsum < -nlim) pacc_q <= 32'(-nlim);
            else pacc_q <= nsum[31:0];
          end else begin
            if (nsum > nlim) yacc_q <= {1'b0, int_lim_q};
            else if (nsum < -nlim) yacc_q <= 32'(-nlim);
            else yacc_q <= nsum[31:0];
          end
          state_q <= S_TM2;
        end
        S_TM2: begin
          prod_q <= mul_p;
          state_q <= S_TM3;
        end
        S_TM3: begin
          v_q <= prod_q;
          prod_q <= mul_p;
          state_q <= S_TM4;
        end
        S_TM4: begin
          v_q <= v_q + prod_q;
          state_q <= S_TFF;
        end
        S_TFF: begin
          oaxis_q  <= ax_q;
          opos_q   <= ax_q ? pgoal_q : ygoal_q;
          off_q    <= ffsat;
          olast_q  <= ~ax_q;
          ovalid_q <= 1'b1;
          state_q  <= S_OUT;
        end
        default: begin
          if (m_axis_tready) begin
            ovalid_q <= 1'b0;
            if (ax_q) begin
              ax_q <= 1'b0;
              state_q <= S_TERR;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {off_q, opos_q};
  assign m_axis_tuser  = oaxis_q;
  assign m_axis_tlast  = olast_q;

endmodule
